// File: sv/ebalu_pkg.sv
// Shared definitions for the eight-bit ALU with flags: operation codes,
// flag bit positions, reset values and the packed transaction layouts.
// Depends on nothing; used by ebalu_core and eight_bit_alu_with_flags.
package ebalu_pkg;

   // Operation codes carried in the command field.
   localparam logic [4:0] CmdAdd    = 5'd0;
   localparam logic [4:0] CmdAdc    = 5'd1;
   localparam logic [4:0] CmdSub    = 5'd2;
   localparam logic [4:0] CmdSbc    = 5'd3;
   localparam logic [4:0] CmdAnd    = 5'd4;
   localparam logic [4:0] CmdXor    = 5'd5;
   localparam logic [4:0] CmdOr     = 5'd6;
   localparam logic [4:0] CmdCp     = 5'd7;
   localparam logic [4:0] CmdInc    = 5'd8;
   localparam logic [4:0] CmdDec    = 5'd9;
   localparam logic [4:0] CmdDaa    = 5'd10;
   localparam logic [4:0] CmdRlca   = 5'd11;
   localparam logic [4:0] CmdRrca   = 5'd12;
   localparam logic [4:0] CmdRla    = 5'd13;
   localparam logic [4:0] CmdRra    = 5'd14;
   localparam logic [4:0] CmdRlc    = 5'd15;
   localparam logic [4:0] CmdRrc    = 5'd16;
   localparam logic [4:0] CmdRl     = 5'd17;
   localparam logic [4:0] CmdRr     = 5'd18;
   localparam logic [4:0] CmdSla    = 5'd19;
   localparam logic [4:0] CmdSra    = 5'd20;
   localparam logic [4:0] CmdSll    = 5'd21;
   localparam logic [4:0] CmdSrl    = 5'd22;
   localparam logic [4:0] CmdBit    = 5'd23;
   localparam logic [4:0] CmdSet    = 5'd24;
   localparam logic [4:0] CmdRes    = 5'd25;
   localparam logic [4:0] CmdAdd16  = 5'd26;
   localparam logic [4:0] CmdAdc16  = 5'd27;
   localparam logic [4:0] CmdSbc16  = 5'd28;
   localparam logic [4:0] CmdLoadAf = 5'd29;

   // Flag register bit positions, S Z Y H X P/V N C from bit 7 down.
   localparam int unsigned FlagS = 7;
   localparam int unsigned FlagZ = 6;
   localparam int unsigned FlagY = 5;
   localparam int unsigned FlagH = 4;
   localparam int unsigned FlagX = 3;
   localparam int unsigned FlagP = 2;
   localparam int unsigned FlagN = 1;
   localparam int unsigned FlagC = 0;

   localparam logic [7:0] AccReset  = 8'hFF;
   localparam logic [7:0] FlagReset = 8'hFF;

   localparam int unsigned ReqDataWidth = 64;
   localparam int unsigned RspDataWidth = 64;

   // Input transaction; the last member sits in the lowest bits.
   typedef struct packed {
      logic [7:0]  addr_high;
      logic        addr_valid;
      logic [15:0] dest16;
      logic [15:0] operand16;
      logic [2:0]  bit_index;
      logic [7:0]  operand8;
      logic [4:0]  command;
   } req_item_type;

   // Result transaction; the last member sits in the lowest bits.
   typedef struct packed {
      logic        wz_valid;
      logic [15:0] wz_out;
      logic [15:0] result16;
      logic [7:0]  result8;
      logic [7:0]  flags_out;
      logic [7:0]  acc_out;
   } rsp_item_type;

   localparam int unsigned ReqPad = ReqDataWidth - $bits(req_item_type);
   localparam int unsigned RspPad = RspDataWidth - $bits(rsp_item_type);

endpackage

// File: sv/ebalu_core.sv
// Combinational datapath of the eight-bit ALU: computes one result
// transaction from one input transaction and the current A and F.
// Depends on ebalu_pkg.
module ebalu_core (
   input  ebalu_pkg::req_item_type item,
   input  logic [7:0]              acc,
   input  logic [7:0]              flags,
   output ebalu_pkg::rsp_item_type result
);

   function automatic logic [7:0] sz53(input logic [7:0] r);
      logic [7:0] f;
      begin
         f = '0;
         f[ebalu_pkg::FlagS] = r[7];
         f[ebalu_pkg::FlagZ] = (r == 8'h00);
         f[ebalu_pkg::FlagY] = r[5];
         f[ebalu_pkg::FlagX] = r[3];
         return f;
      end
   endfunction

   function automatic logic [7:0] sz53p(input logic [7:0] r);
      logic [7:0] f;
      begin
         f = sz53(r);
         f[ebalu_pkg::FlagP] = ~^r;
         return f;
      end
   endfunction

   logic [4:0]  cmd;
   logic [7:0]  a, v, f, keep, r8, corr, na, xy_src;
   logic [8:0]  t9;
   logic [16:0] t17;
   logic [15:0] d, w, r16, wz;
   logic        wzv, cin, is_sub, carry8, is_sub16, carry16, cy, c, tb, nf;
   logic [7:0]  af;

   always_comb begin
      cmd  = item.command;
      v    = item.operand8;
      d    = item.dest16;
      w    = item.operand16;
      a    = acc;
      f    = flags;
      cin  = flags[ebalu_pkg::FlagC];
      keep = flags & 8'hC4;   // S, Z and P/V survive the rotates and ADD16
      r8   = '0;
      r16  = '0;
      wz   = '0;
      wzv  = 1'b0;
      c    = 1'b0;
      corr = '0;
      na   = '0;
      cy   = 1'b0;
      nf   = 1'b0;
      tb   = 1'b0;

      // Shared 8-bit adder for ADD, ADC, SUB, SBC and CP.
      is_sub = (cmd == ebalu_pkg::CmdSub) || (cmd == ebalu_pkg::CmdSbc)
               || (cmd == ebalu_pkg::CmdCp);
      carry8 = ((cmd == ebalu_pkg::CmdAdc) || (cmd == ebalu_pkg::CmdSbc)) ? cin : 1'b0;
      if (is_sub) begin
         t9 = {1'b0, acc} - {1'b0, v} - {8'b0, carry8};
      end else begin
         t9 = {1'b0, acc} + {1'b0, v} + {8'b0, carry8};
      end
      af = '0;
      af[ebalu_pkg::FlagN] = is_sub;
      af[ebalu_pkg::FlagC] = t9[8];
      af[ebalu_pkg::FlagH] = acc[4] ^ v[4] ^ t9[4];
      af[ebalu_pkg::FlagP] = is_sub ? ((acc[7] ^ v[7]) & (acc[7] ^ t9[7]))
                                    : (~(acc[7] ^ v[7]) & (acc[7] ^ t9[7]));

      // Shared 17-bit adder for the word operations.
      is_sub16 = (cmd == ebalu_pkg::CmdSbc16);
      carry16  = (cmd == ebalu_pkg::CmdAdd16) ? 1'b0 : cin;
      if (is_sub16) begin
         t17 = {1'b0, d} - {1'b0, w} - {16'b0, carry16};
      end else begin
         t17 = {1'b0, d} + {1'b0, w} + {16'b0, carry16};
      end

      xy_src = item.addr_valid ? item.addr_high : v;

      unique case (cmd)
         ebalu_pkg::CmdAdd, ebalu_pkg::CmdAdc, ebalu_pkg::CmdSub, ebalu_pkg::CmdSbc: begin
            a = t9[7:0];
            f = af | sz53(t9[7:0]);
         end
         ebalu_pkg::CmdAnd: begin
            a = acc & v;
            f = sz53p(acc & v);
            f[ebalu_pkg::FlagH] = 1'b1;
         end
         ebalu_pkg::CmdXor: begin
            a = acc ^ v;
            f = sz53p(acc ^ v);
         end
         ebalu_pkg::CmdOr: begin
            a = acc | v;
            f = sz53p(acc | v);
         end
         ebalu_pkg::CmdCp: begin
            // Compare keeps A; X and Y copy the operand, not the difference.
            f = af;
            f[ebalu_pkg::FlagS] = t9[7];
            f[ebalu_pkg::FlagZ] = (t9[7:0] == 8'h00);
            f[ebalu_pkg::FlagY] = v[5];
            f[ebalu_pkg::FlagX] = v[3];
         end
         ebalu_pkg::CmdInc: begin
            r8 = v + 8'd1;
            f = sz53(r8);
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagH] = (r8[3:0] == 4'h0);
            f[ebalu_pkg::FlagP] = (r8 == 8'h80);
         end
         ebalu_pkg::CmdDec: begin
            r8 = v - 8'd1;
            f = sz53(r8);
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagN] = 1'b1;
            f[ebalu_pkg::FlagH] = (r8[3:0] == 4'hF);
            f[ebalu_pkg::FlagP] = (r8 == 8'h7F);
         end
         ebalu_pkg::CmdDaa: begin
            nf   = flags[ebalu_pkg::FlagN];
            cy   = cin || (acc > 8'h99);
            corr = ((flags[ebalu_pkg::FlagH] || (acc[3:0] > 4'd9)) ? 8'h06 : 8'h00)
                   | (cy ? 8'h60 : 8'h00);
            na   = nf ? (acc - corr) : (acc + corr);
            f    = sz53p(na);
            f[ebalu_pkg::FlagN] = nf;
            f[ebalu_pkg::FlagC] = cy;
            f[ebalu_pkg::FlagH] = acc[4] ^ na[4];
            a    = na;
         end
         ebalu_pkg::CmdRlca, ebalu_pkg::CmdRrca, ebalu_pkg::CmdRla, ebalu_pkg::CmdRra: begin
            unique case (cmd)
               ebalu_pkg::CmdRlca: begin
                  c = acc[7];
                  a = {acc[6:0], acc[7]};
               end
               ebalu_pkg::CmdRrca: begin
                  c = acc[0];
                  a = {acc[0], acc[7:1]};
               end
               ebalu_pkg::CmdRla: begin
                  c = acc[7];
                  a = {acc[6:0], cin};
               end
               default: begin
                  c = acc[0];
                  a = {cin, acc[7:1]};
               end
            endcase
            f = keep;
            f[ebalu_pkg::FlagC] = c;
            f[ebalu_pkg::FlagY] = a[5];
            f[ebalu_pkg::FlagX] = a[3];
         end
         ebalu_pkg::CmdRlc, ebalu_pkg::CmdRrc, ebalu_pkg::CmdRl, ebalu_pkg::CmdRr,
         ebalu_pkg::CmdSla, ebalu_pkg::CmdSra, ebalu_pkg::CmdSll, ebalu_pkg::CmdSrl: begin
            unique case (cmd)
               ebalu_pkg::CmdRlc: begin
                  c  = v[7];
                  r8 = {v[6:0], v[7]};
               end
               ebalu_pkg::CmdRrc: begin
                  c  = v[0];
                  r8 = {v[0], v[7:1]};
               end
               ebalu_pkg::CmdRl: begin
                  c  = v[7];
                  r8 = {v[6:0], cin};
               end
               ebalu_pkg::CmdRr: begin
                  c  = v[0];
                  r8 = {cin, v[7:1]};
               end
               ebalu_pkg::CmdSla: begin
                  c  = v[7];
                  r8 = {v[6:0], 1'b0};
               end
               ebalu_pkg::CmdSra: begin
                  c  = v[0];
                  r8 = {v[7], v[7:1]};
               end
               ebalu_pkg::CmdSll: begin
                  c  = v[7];
                  r8 = {v[6:0], 1'b1};
               end
               default: begin
                  c  = v[0];
                  r8 = {1'b0, v[7:1]};
               end
            endcase
            f = sz53p(r8);
            f[ebalu_pkg::FlagC] = c;
         end
         ebalu_pkg::CmdBit: begin
            tb = v[item.bit_index];
            f  = '0;
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagH] = 1'b1;
            f[ebalu_pkg::FlagZ] = ~tb;
            f[ebalu_pkg::FlagP] = ~tb;
            f[ebalu_pkg::FlagS] = (item.bit_index == 3'd7) && tb;
            f[ebalu_pkg::FlagY] = xy_src[5];
            f[ebalu_pkg::FlagX] = xy_src[3];
         end
         ebalu_pkg::CmdSet: begin
            r8 = v | (8'h01 << item.bit_index);
         end
         ebalu_pkg::CmdRes: begin
            r8 = v & ~(8'h01 << item.bit_index);
         end
         ebalu_pkg::CmdAdd16: begin
            r16 = t17[15:0];
            f   = keep;
            f[ebalu_pkg::FlagH] = d[12] ^ w[12] ^ t17[12];
            f[ebalu_pkg::FlagC] = t17[16];
            f[ebalu_pkg::FlagY] = t17[13];
            f[ebalu_pkg::FlagX] = t17[11];
            wz  = d + 16'd1;
            wzv = 1'b1;
         end
         ebalu_pkg::CmdAdc16, ebalu_pkg::CmdSbc16: begin
            r16 = t17[15:0];
            f   = '0;
            f[ebalu_pkg::FlagN] = is_sub16;
            f[ebalu_pkg::FlagP] = is_sub16 ? ((d[15] ^ w[15]) & (d[15] ^ t17[15]))
                                           : (~(d[15] ^ w[15]) & (d[15] ^ t17[15]));
            f[ebalu_pkg::FlagS] = t17[15];
            f[ebalu_pkg::FlagZ] = (t17[15:0] == 16'h0000);
            f[ebalu_pkg::FlagH] = d[12] ^ w[12] ^ t17[12];
            f[ebalu_pkg::FlagC] = t17[16];
            f[ebalu_pkg::FlagY] = t17[13];
            f[ebalu_pkg::FlagX] = t17[11];
            wz  = d + 16'd1;
            wzv = 1'b1;
         end
         ebalu_pkg::CmdLoadAf: begin
            a = w[15:8];
            f = w[7:0];
         end
         default: begin
            // Unused codes leave A and F as they are.
            a = acc;
            f = flags;
         end
      endcase

      result.acc_out   = a;
      result.flags_out = f;
      result.result8   = r8;
      result.result16  = r16;
      result.wz_out    = wz;
      result.wz_valid  = wzv;
   end

endmodule

// File: sv/eight_bit_alu_with_flags.sv
// Top level of the eight-bit ALU with flags: input register, datapath,
// result register and the kept accumulator and flag register.
// Depends on ebalu_pkg and ebalu_core.
//
// This block is an 8-bit CPU arithmetic unit that owns the accumulator (A) and
// the flag register (F), both 0xFF after reset. Each request transaction names
// one operation and its operands and produces exactly one response transaction
// with the new A and F, the byte result, the word result and the memptr value.
// An accepted request is held in the input register, the whole operation is
// then done by one pass of combinational logic, and the response is held in
// the output register. While the response side is ready, the block takes one
// request per cycle, sustained: A and F are updated in the same cycle the
// result is registered, so the next request always sees the state that the
// previous one left. When the response side stalls, the input register holds
// its transaction and req_tready drops only once both registers are full.
module eight_bit_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   // Request fields from bit 0 up: command[4:0], operand8[12:5],
   // bit_index[15:13], operand16[31:16], dest16[47:32], addr_valid[48],
   // addr_high[56:49]; bits 63:57 are zero.
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Response fields from bit 0 up: acc_out[7:0], flags_out[15:8],
   // result8[23:16], result16[39:24], wz_out[55:40], wz_valid[56];
   // bits 63:57 are zero.
   output logic [63:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   ebalu_pkg::req_item_type in_ff, in_in;
   ebalu_pkg::rsp_item_type out_ff, core_result;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              acc_ff, flag_ff;
   logic                    req_accept, out_free, advance;

   // The output register can take a new result when it is empty or its
   // current transaction leaves in this cycle.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_in       = req_tdata[$bits(ebalu_pkg::req_item_type)-1:0];
   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   ebalu_core u_core (
      .item   (in_ff),
      .acc    (acc_ff),
      .flags  (flag_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= ebalu_pkg::AccReset;
         flag_ff      <= ebalu_pkg::FlagReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            acc_ff  <= core_result.acc_out;
            flag_ff <= core_result.flags_out;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{ebalu_pkg::RspPad{1'b0}}, out_ff};

   // The kept A and F always match the newest registered result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (acc_ff == out_ff.acc_out) && (flag_ff == out_ff.flags_out))
      else $error("accumulator or flags out of step with the result register");

   // Reset restores the documented A and F and empties both registers.
   assert property (@(posedge clock)
      reset |=> (acc_ff == ebalu_pkg::AccReset) && (flag_ff == ebalu_pkg::FlagReset)
                && !in_valid_ff && !out_valid_ff)
      else $error("reset state wrong");

   // A transaction waiting in the input register is neither lost nor altered.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a waiting transaction");

   // Word fields are zero unless a word operation wrote them.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.wz_valid) |-> (out_ff.wz_out == 16'h0000)
                                             && (out_ff.result16 == 16'h0000))
      else $error("word result reported without a word operation");

endmodule

// File: test/eight_bit_alu_with_flags_tb.sv
// Self-checking testbench for eight_bit_alu_with_flags: a directed table, then random
// transactions in four handshake-pressure phases, scored by a model or typed values.
// Depends on ebalu_pkg and the RTL of eight_bit_alu_with_flags.
module eight_bit_alu_with_flags_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The two command codes that the block treats as no operation.
   localparam logic [4:0] CmdSpare30 = 5'd30;
   localparam logic [4:0] CmdSpare31 = 5'd31;

   // Flag masks built from the bit positions in the package.
   localparam logic [7:0] MaskS   = 8'(1 << ebalu_pkg::FlagS);
   localparam logic [7:0] MaskYX  = 8'((1 << ebalu_pkg::FlagY) | (1 << ebalu_pkg::FlagX));
   localparam logic [7:0] MaskSZP = 8'((1 << ebalu_pkg::FlagS) | (1 << ebalu_pkg::FlagZ)
                                       | (1 << ebalu_pkg::FlagP));

   localparam int NumDirected   = 37;
   localparam int PhaseItems    = 375;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 8;
   localparam int MaxReports    = 10;

   // One row of the directed table. When typed is set, acc and flags are the
   // response values read straight off the operation; the other result fields
   // of those rows are zero. Rows without typed are scored by the model.
   typedef struct packed {
      logic [4:0]  cmd;
      logic [7:0]  op8;
      logic [2:0]  bit_idx;
      logic [15:0] op16;
      logic [15:0] d16;
      logic        av;
      logic [7:0]  ah;
      logic        typed;
      logic [7:0]  acc;
      logic [7:0]  flags;
   } directed_row_type;

   // A response that is owed, kept with the request that caused it so that a
   // mismatch report can show the operands.
   typedef struct {
      ebalu_pkg::req_item_type rq;
      ebalu_pkg::rsp_item_type rsp;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [63:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   // Model copy of the accumulator and flag register.
   logic [7:0] model_acc;
   logic [7:0] model_flags;

   pending_type pending_results [$];
   int          fault_count = 0;
   int          idle_cycles = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;

   // Directed table: every operation at least once, the operand extremes, both
   // forms of BIT, both directions of DAA and the two unused codes. Rows whose
   // response follows at a glance (the unused code right after reset, the loads
   // of A and F, and the ADD after the first load) carry it typed in.
   directed_row_type directed_rows [NumDirected] = '{
      // cmd                  op8    bit   op16      dest16    av    ah     typed acc    flags
      '{CmdSpare30,           8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, 8'hFF, 8'hFF},
      '{ebalu_pkg::CmdLoadAf, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00},
      '{ebalu_pkg::CmdAdd,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1, 8'h00, 8'h40},
      '{ebalu_pkg::CmdAdc,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSub,    8'h7F, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSbc,    8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdAnd,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdXor,    8'hAA, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdOr,     8'h55, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdCp,     8'h28, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdInc,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdDec,    8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdLoadAf, 8'h00, 3'd0, 16'h9A11, 16'h0000, 1'b0, 8'h00, 1'b1, 8'h9A, 8'h11},
      '{ebalu_pkg::CmdDaa,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdLoadAf, 8'h00, 3'd0, 16'h0F12, 16'h0000, 1'b0, 8'h00, 1'b1, 8'h0F, 8'h12},
      '{ebalu_pkg::CmdDaa,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRlca,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRrca,   8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRla,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRra,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRlc,    8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRrc,    8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRl,     8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRr,     8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSla,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSra,    8'h81, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSll,    8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSrl,    8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdBit,    8'h80, 3'd7, 16'h0000, 16'h0000, 1'b1, 8'h28, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdBit,    8'hFE, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSet,    8'h00, 3'd7, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdRes,    8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdAdd16,  8'h00, 3'd0, 16'h0001, 16'hFFFF, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdAdc16,  8'h00, 3'd0, 16'h0000, 16'h7FFF, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdSbc16,  8'h00, 3'd0, 16'h0001, 16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CmdSpare31,           8'hFF, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{ebalu_pkg::CmdLoadAf, 8'h00, 3'd0, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b1, 8'hFF, 8'hFF}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   eight_bit_alu_with_flags i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Sign, zero and the two undocumented copies of bits 5 and 3.
   function automatic logic [7:0] sign_zero_xy(input logic [7:0] r);
      logic [7:0] fl;
      fl = r & (MaskS | MaskYX);
      fl[ebalu_pkg::FlagZ] = (r == 8'h00);
      return fl;
   endfunction

   // As above, with P/V as even parity, the way logic and shift operations set it.
   function automatic logic [7:0] sign_zero_xy_parity(input logic [7:0] r);
      logic [7:0] fl;
      fl = sign_zero_xy(r);
      fl[ebalu_pkg::FlagP] = ~^r;
      return fl;
   endfunction

   // Performs one operation on the model accumulator and flags and returns the
   // response that the block must give for it.
   function automatic ebalu_pkg::rsp_item_type alu_execute(input ebalu_pkg::req_item_type rq);
      ebalu_pkg::rsp_item_type rs;
      logic [7:0]   a, f, v, r, keep, corr;
      logic [8:0]   s9;
      logic [16:0]  s17;
      logic         cin, cy, sub, cl;
      a    = model_acc;
      f    = model_flags;
      v    = rq.operand8;
      cin  = f[ebalu_pkg::FlagC];
      keep = f & MaskSZP;
      rs   = '0;
      case (rq.command)
         ebalu_pkg::CmdAdd, ebalu_pkg::CmdAdc, ebalu_pkg::CmdSub, ebalu_pkg::CmdSbc,
         ebalu_pkg::CmdCp: begin
            sub = !(rq.command == ebalu_pkg::CmdAdd || rq.command == ebalu_pkg::CmdAdc);
            cl  = (rq.command == ebalu_pkg::CmdAdc || rq.command == ebalu_pkg::CmdSbc)
                  ? cin : 1'b0;
            // Nine bits wide, so bit 8 is the carry out or the borrow.
            s9  = sub ? ({1'b0, a} - {1'b0, v} - 9'(cl)) : ({1'b0, a} + {1'b0, v} + 9'(cl));
            r   = s9[7:0];
            f   = '0;
            f[ebalu_pkg::FlagN] = sub;
            f[ebalu_pkg::FlagC] = s9[8];
            f[ebalu_pkg::FlagH] = a[4] ^ v[4] ^ r[4];
            f[ebalu_pkg::FlagP] = sub ? ((a[7] ^ v[7]) & (a[7] ^ r[7]))
                                      : (~(a[7] ^ v[7]) & (a[7] ^ r[7]));
            // Compare keeps A, and takes bits 5 and 3 from the operand.
            if (rq.command == ebalu_pkg::CmdCp) begin
               f |= (sign_zero_xy(r) & ~MaskYX) | (v & MaskYX);
            end else begin
               f |= sign_zero_xy(r);
               a = r;
            end
         end
         ebalu_pkg::CmdAnd: begin
            a = a & v;
            f = sign_zero_xy_parity(a);
            f[ebalu_pkg::FlagH] = 1'b1;
         end
         ebalu_pkg::CmdXor: begin
            a = a ^ v;
            f = sign_zero_xy_parity(a);
         end
         ebalu_pkg::CmdOr: begin
            a = a | v;
            f = sign_zero_xy_parity(a);
         end
         ebalu_pkg::CmdInc: begin
            r = v + 8'd1;
            f = sign_zero_xy(r);
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagH] = (r[3:0] == 4'h0);
            f[ebalu_pkg::FlagP] = (r == 8'h80);
            rs.result8 = r;
         end
         ebalu_pkg::CmdDec: begin
            r = v - 8'd1;
            f = sign_zero_xy(r);
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagN] = 1'b1;
            f[ebalu_pkg::FlagH] = (r[3:0] == 4'hF);
            f[ebalu_pkg::FlagP] = (r == 8'h7F);
            rs.result8 = r;
         end
         ebalu_pkg::CmdDaa: begin
            // Low correction on H or a nibble above nine, high on C or A above 0x99;
            // N decides whether the correction is added or taken away.
            cy   = cin || (a > 8'h99);
            corr = '0;
            if (f[ebalu_pkg::FlagH] || (a[3:0] > 4'd9)) corr |= 8'h06;
            if (cy) corr |= 8'h60;
            sub = f[ebalu_pkg::FlagN];
            r   = sub ? (a - corr) : (a + corr);
            f   = sign_zero_xy_parity(r);
            f[ebalu_pkg::FlagN] = sub;
            f[ebalu_pkg::FlagC] = cy;
            f[ebalu_pkg::FlagH] = a[4] ^ r[4];
            a = r;
         end
         ebalu_pkg::CmdRlca, ebalu_pkg::CmdRrca, ebalu_pkg::CmdRla, ebalu_pkg::CmdRra: begin
            case (rq.command)
               ebalu_pkg::CmdRlca: begin cy = a[7]; a = {a[6:0], a[7]}; end
               ebalu_pkg::CmdRrca: begin cy = a[0]; a = {a[0], a[7:1]}; end
               ebalu_pkg::CmdRla:  begin cy = a[7]; a = {a[6:0], cin}; end
               default: begin cy = a[0]; a = {cin, a[7:1]}; end
            endcase
            // S, Z and P/V survive; H and N clear.
            f = keep | (a & MaskYX);
            f[ebalu_pkg::FlagC] = cy;
         end
         ebalu_pkg::CmdRlc, ebalu_pkg::CmdRrc, ebalu_pkg::CmdRl, ebalu_pkg::CmdRr,
         ebalu_pkg::CmdSla, ebalu_pkg::CmdSra, ebalu_pkg::CmdSll, ebalu_pkg::CmdSrl: begin
            case (rq.command)
               ebalu_pkg::CmdRlc:  begin cy = v[7]; r = {v[6:0], v[7]}; end
               ebalu_pkg::CmdRrc:  begin cy = v[0]; r = {v[0], v[7:1]}; end
               ebalu_pkg::CmdRl:   begin cy = v[7]; r = {v[6:0], cin}; end
               ebalu_pkg::CmdRr:   begin cy = v[0]; r = {cin, v[7:1]}; end
               ebalu_pkg::CmdSla:  begin cy = v[7]; r = {v[6:0], 1'b0}; end
               ebalu_pkg::CmdSra:  begin cy = v[0]; r = {v[7], v[7:1]}; end
               ebalu_pkg::CmdSll:  begin cy = v[7]; r = {v[6:0], 1'b1}; end
               default: begin cy = v[0]; r = {1'b0, v[7:1]}; end
            endcase
            f = sign_zero_xy_parity(r);
            f[ebalu_pkg::FlagC] = cy;
            rs.result8 = r;
         end
         ebalu_pkg::CmdBit: begin
            cy = v[rq.bit_index];
            f  = '0;
            f[ebalu_pkg::FlagC] = cin;
            f[ebalu_pkg::FlagH] = 1'b1;
            f[ebalu_pkg::FlagZ] = !cy;
            f[ebalu_pkg::FlagP] = !cy;
            f[ebalu_pkg::FlagS] = cy && (rq.bit_index == 3'd7);
            // Memory form takes bits 5 and 3 from the high address byte.
            f |= (rq.addr_valid ? rq.addr_high : v) & MaskYX;
         end
         ebalu_pkg::CmdSet: begin
            rs.result8 = v | (8'd1 << rq.bit_index);
         end
         ebalu_pkg::CmdRes: begin
            rs.result8 = v & ~(8'd1 << rq.bit_index);
         end
         ebalu_pkg::CmdAdd16: begin
            s17 = {1'b0, rq.dest16} + {1'b0, rq.operand16};
            f = keep;
            f[ebalu_pkg::FlagH] = rq.dest16[12] ^ rq.operand16[12] ^ s17[12];
            f[ebalu_pkg::FlagC] = s17[16];
            f[ebalu_pkg::FlagY] = s17[13];
            f[ebalu_pkg::FlagX] = s17[11];
            rs.result16 = s17[15:0];
            rs.wz_out   = rq.dest16 + 16'd1;
            rs.wz_valid = 1'b1;
         end
         ebalu_pkg::CmdAdc16, ebalu_pkg::CmdSbc16: begin
            sub = (rq.command == ebalu_pkg::CmdSbc16);
            s17 = sub ? ({1'b0, rq.dest16} - {1'b0, rq.operand16} - 17'(cin))
                      : ({1'b0, rq.dest16} + {1'b0, rq.operand16} + 17'(cin));
            f = '0;
            f[ebalu_pkg::FlagN] = sub;
            f[ebalu_pkg::FlagP] = sub
               ? ((rq.dest16[15] ^ rq.operand16[15]) & (rq.dest16[15] ^ s17[15]))
               : (~(rq.dest16[15] ^ rq.operand16[15]) & (rq.dest16[15] ^ s17[15]));
            f[ebalu_pkg::FlagS] = s17[15];
            f[ebalu_pkg::FlagZ] = (s17[15:0] == 16'h0000);
            f[ebalu_pkg::FlagH] = rq.dest16[12] ^ rq.operand16[12] ^ s17[12];
            f[ebalu_pkg::FlagC] = s17[16];
            f[ebalu_pkg::FlagY] = s17[13];
            f[ebalu_pkg::FlagX] = s17[11];
            rs.result16 = s17[15:0];
            rs.wz_out   = rq.dest16 + 16'd1;
            rs.wz_valid = 1'b1;
         end
         ebalu_pkg::CmdLoadAf: begin
            a = rq.operand16[15:8];
            f = rq.operand16[7:0];
         end
         default: begin
         end
      endcase
      model_acc   = a;
      model_flags = f;
      rs.acc_out   = a;
      rs.flags_out = f;
      return rs;
   endfunction

   // A byte that lands on one of the edge values about four times in ten.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // Random request. Loads of A and F are frequent so that DAA, the carry-in
   // operations and the flag-keeping rotates see all flag patterns.
   function automatic ebalu_pkg::req_item_type random_request();
      ebalu_pkg::req_item_type rq;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         rq.command = ebalu_pkg::CmdLoadAf;
      end else if (roll < 14) begin
         rq.command = roll[0] ? CmdSpare31 : CmdSpare30;
      end else begin
         rq.command = 5'($urandom_range(ebalu_pkg::CmdAdd, ebalu_pkg::CmdSbc16));
      end
      rq.operand8   = pick_byte();
      rq.bit_index  = 3'($urandom);
      rq.operand16  = {pick_byte(), pick_byte()};
      rq.dest16     = {pick_byte(), pick_byte()};
      rq.addr_valid = 1'($urandom);
      rq.addr_high  = 8'($urandom);
      return rq;
   endfunction

   // Presents one request transaction, called and returning at a falling edge.
   // Valid is lowered only inside an idle gap, so it stays high across
   // back-to-back transactions. The expected response is worked out at the
   // rising edge that accepts the request, so the model state follows the
   // order in which the block takes them.
   task automatic send_request(input ebalu_pkg::req_item_type rq, input logic typed,
                               input ebalu_pkg::rsp_item_type typed_rsp);
      pending_type entry;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{ebalu_pkg::ReqPad{1'b0}}, rq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.rq  = rq;
      entry.rsp = alu_execute(rq);
      if (typed) entry.rsp = typed_rsp;
      pending_results.push_back(entry);
      @(negedge clock);
   endtask

   // Scores one accepted response against the oldest owed one.
   task automatic check_result(input ebalu_pkg::rsp_item_type got);
      pending_type want;
      if (pending_results.size() == 0) begin
         fault_count++;
         if (fault_count <= MaxReports) begin
            $display("%0t: response with no request outstanding: acc=%h flags=%h",
                     $time, got.acc_out, got.flags_out);
         end
      end else begin
         want = pending_results.pop_front();
         if (got !== want.rsp) begin
            fault_count++;
            if (fault_count <= MaxReports) begin
               $display("%0t: mismatch on cmd %0d op8=%h bit=%0d op16=%h dest16=%h av=%b ah=%h",
                        $time, want.rq.command, want.rq.operand8, want.rq.bit_index,
                        want.rq.operand16, want.rq.dest16, want.rq.addr_valid,
                        want.rq.addr_high);
               $display("   expected acc=%h flags=%h r8=%h r16=%h wz=%h wzv=%b",
                        want.rsp.acc_out, want.rsp.flags_out, want.rsp.result8,
                        want.rsp.result16, want.rsp.wz_out, want.rsp.wz_valid);
               $display("   actual   acc=%h flags=%h r8=%h r16=%h wz=%h wzv=%b",
                        got.acc_out, got.flags_out, got.result8,
                        got.result16, got.wz_out, got.wz_valid);
            end
         end
      end
   endtask

   // The receiver changes its ready at every falling edge; the stall rate is
   // set by the phase that the stimulus is in.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Response monitor and watchdog. The watchdog counts cycles without any
   // transaction on either side, so it trips on a hang but not on a long run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata[$bits(ebalu_pkg::rsp_item_type)-1:0]);
         end
      end
   end

   initial begin
      directed_row_type        row;
      ebalu_pkg::req_item_type rq;
      ebalu_pkg::rsp_item_type typed_rsp;

      // The model starts from the reset state of A and F.
      model_acc   = ebalu_pkg::AccReset;
      model_flags = ebalu_pkg::FlagReset;

      // Synchronous reset first; everything is driven at falling edges.
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The directed part runs with light idling on both sides.
      req_idle_pct  = 26;
      rsp_stall_pct = 26;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         rq.command    = row.cmd;
         rq.operand8   = row.op8;
         rq.bit_index  = row.bit_idx;
         rq.operand16  = row.op16;
         rq.dest16     = row.d16;
         rq.addr_valid = row.av;
         rq.addr_high  = row.ah;
         typed_rsp           = '0;
         typed_rsp.acc_out   = row.acc;
         typed_rsp.flags_out = row.flags;
         send_request(rq, row.typed, typed_rsp);
      end

      // Random part in four phases: no idling, a slow sender, a slow
      // receiver, and both sides idling part of the time.
      typed_rsp = '0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 57; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 57; end
            default: begin req_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            send_request(random_request(), 1'b0, typed_rsp);
         end
      end
      req_tvalid <= 1'b0;

      // Wait for every owed response, then keep the monitor running so that a
      // spurious extra response would still be caught by it.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ebalu_pkg.sv
sv/ebalu_core.sv
sv/eight_bit_alu_with_flags.sv
test/eight_bit_alu_with_flags_tb.sv
